// File: hw/rtl/rmf_pkg.sv
// ----------------------------------------------------------------------------
// rmf_pkg: shared types and constants of the RGB median filter
// Frame limits, pixel and window types, request codes and the structs that
// travel between the control, window and median stages.
// ----------------------------------------------------------------------------
package rmf_pkg;

  // Largest frame the line store is sized for.
  localparam int MaxWidth  = 640;
  localparam int MaxHeight = 480;

  // Counter and address widths follow from the frame limits.
  localparam int ColAddrW = $clog2(MaxWidth);
  localparam int RowAddrW = $clog2(MaxHeight);

  // Configuration register widths and reset values.
  localparam int CfgWidthW   = 10;
  localparam int CfgHeightW  = 9;
  localparam int CfgDataW    = 10;
  localparam int WidthReset  = 640;
  localparam int HeightReset = 480;

  // Pixel layout: red in the low byte, then green, then blue.
  localparam int ChanW     = 8;
  localparam int PixW      = 3 * ChanW;
  localparam int BrW       = ChanW + 2;
  localparam int WinSize   = 9;
  localparam int WinCenter = 4;
  localparam int MedRank   = 4;
  localparam int RankW     = $clog2(WinSize);

  typedef logic [PixW-1:0] pix_t;

  // One column of the window: index 0 is the top row, 2 the bottom row.
  typedef logic [2:0][PixW-1:0] col_t;

  // 3x3 window in row-major order.
  typedef logic [WinSize-1:0][PixW-1:0] win_t;

  // Line store word: the two rows above the incoming pixel.
  typedef struct packed {
    pix_t top;
    pix_t mid;
  } line_word_t;

  typedef enum logic {
    ActPixel = 1'b0,
    ActDrain = 1'b1
  } action_e;

  typedef enum logic {
    RegFrameWidth  = 1'b0,
    RegFrameHeight = 1'b1
  } cfg_reg_e;

  // Work handed from the control to the window stage.
  typedef struct packed {
    logic                wr;        // pixel goes into the line store
    logic                emit;      // request produces an output pixel
    logic                from_mem;  // output pixel comes from the store
    logic                interior;  // output pixel takes the median
    logic                last;      // last output pixel of the frame
    logic [ColAddrW-1:0] col;       // line store column
    pix_t                pix;       // incoming pixel
  } item_t;

  // Flags that ride along with a window through the median stages.
  typedef struct packed {
    logic interior;
    logic last;
  } tag_t;

endpackage

// File: hw/rtl/rgb_median3x3_by_brightness.sv
// ----------------------------------------------------------------------------
// rgb_median3x3_by_brightness: 3x3 brightness median filter for RGB frames
// Streams pixels of one frame in raster order and returns filtered pixels.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries requests: tuser = 0 delivers a pixel in tdata
//   (red in bits 7:0, green 15:8, blue 23:16), tuser = 1 is a drain request
//   that flushes one pending output once the whole frame is in. Pixels sent
//   after the frame is complete and drains sent too early are dropped.
//   Output pixel (r, c) is due with the input pixel one row plus one pixel
//   later in raster order; border pixels are copied, interior pixels take the
//   median of their 3x3 window ordered by r+g+b with ties kept in row-major
//   order. tlast marks the frame's last output, after which the next pixel
//   starts a new frame.
//   The config channel is always ready: index 0 sets frame width, index 1
//   frame height; either write restarts the frame. Write it only when idle.
//   Throughput is one request per cycle unless the master side stalls, set
//   by the single line store RAM (640 x 48 bits) read and written once per
//   pixel. Outputs are registered in the read, window, sum, order and output
//   stages. Reset restores a 640 x 480 frame and empties the pipeline; line
//   store contents are undefined; unwritten words feed only border windows.
//   When the master side stalls, results wait in the pipeline registers and
//   new requests are taken until every stage is full.
// ----------------------------------------------------------------------------
module rgb_median3x3_by_brightness import rmf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write channel.
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // Request stream.
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [23:0]         s_axis_tdata_i,   // red, green, blue
  input  logic                s_axis_tuser_i,   // action
  // Result stream.
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [23:0]         m_axis_tdata_o,   // red_out, green_out, blue_out
  output logic                m_axis_tlast_o    // frame_end
);

  logic  item_valid, win_ready, win_ready_med, win_valid;
  item_t item;
  win_t  win;
  tag_t  tag;
  pix_t  out_pix;

  assign cfg_ready_o = 1'b1;

  // Position tracking and request decode.
  rmf_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid_i),
    .in_action_i  (s_axis_tuser_i),
    .in_pix_i     (s_axis_tdata_i),
    .ready_i      (win_ready),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  assign s_axis_tready_o = win_ready;

  // Line store and window assembly.
  rmf_window u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .ready_o      (win_ready),
    .win_valid_o  (win_valid),
    .win_ready_i  (win_ready_med),
    .win_o        (win),
    .tag_o        (tag)
  );

  // Median network and output register.
  rmf_median u_median (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (win_valid),
    .ready_o     (win_ready_med),
    .win_i       (win),
    .tag_i       (tag),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_pix_o   (out_pix),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = out_pix;

endmodule

// File: hw/rtl/rmf_ram.sv
// ----------------------------------------------------------------------------
// rmf_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered and held
// while the read enable is low.
// ----------------------------------------------------------------------------
module rmf_ram #(
  parameter int Width = 48,
  parameter int Depth = 640
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/rmf_ctrl.sv
// ----------------------------------------------------------------------------
// rmf_ctrl: frame position counters and configuration registers
// Decides for each request whether it stores a pixel, emits an output
// pixel, or is dropped, and tracks input and output raster positions.
// ----------------------------------------------------------------------------
module rmf_ctrl import rmf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic                cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_action_i,
  input  pix_t                in_pix_i,
  input  logic                ready_i,
  output logic                item_valid_o,
  output item_t               item_o
);

  logic [CfgWidthW-1:0]  cfg_width_q;
  logic [CfgHeightW-1:0] cfg_height_q;
  logic [ColAddrW-1:0]   in_col_q, out_col_q, w_last;
  logic [RowAddrW-1:0]   in_row_q, out_row_q, h_last;
  logic                  in_done_q;
  logic                  accept, is_pixel, do_wr, emit_px, emit_dr, emit;
  logic                  interior, last;

  // Clamp the configured size into the supported range.
  always_comb begin
    if (cfg_width_q == '0) begin
      w_last = '0;
    end else if (32'(cfg_width_q) > MaxWidth) begin
      w_last = ColAddrW'(MaxWidth - 1);
    end else begin
      w_last = ColAddrW'(cfg_width_q - 1'b1);
    end
    if (cfg_height_q == '0) begin
      h_last = '0;
    end else if (32'(cfg_height_q) > MaxHeight) begin
      h_last = RowAddrW'(MaxHeight - 1);
    end else begin
      h_last = RowAddrW'(cfg_height_q - 1'b1);
    end
  end

  // Classify the request.
  always_comb begin
    accept   = in_valid_i && ready_i;
    is_pixel = (action_e'(in_action_i) == ActPixel);
    do_wr    = accept && is_pixel && !in_done_q;
    // An output is due once a full row plus one pixel is in.
    emit_px  = do_wr && ((in_row_q > RowAddrW'(1)) ||
                         (in_row_q == RowAddrW'(1) && in_col_q != '0));
    emit_dr  = accept && !is_pixel && in_done_q;
    emit     = emit_px || emit_dr;
    interior = (out_row_q != '0) && (out_col_q != '0) &&
               (out_row_q != h_last) && (out_col_q != w_last);
    last     = (out_row_q == h_last) && (out_col_q == w_last);
  end

  always_comb begin
    item_valid_o     = do_wr || emit;
    item_o.wr        = do_wr;
    item_o.emit      = emit;
    // Last row pixels still pending at the end come from the store.
    item_o.from_mem  = emit_dr && (out_row_q == h_last);
    item_o.interior  = interior;
    item_o.last      = last;
    item_o.col       = is_pixel ? in_col_q : out_col_q;
    item_o.pix       = in_pix_i;
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= CfgWidthW'(WidthReset);
      cfg_height_q <= CfgHeightW'(HeightReset);
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        RegFrameWidth:  cfg_width_q  <= cfg_data_i[CfgWidthW-1:0];
        RegFrameHeight: cfg_height_q <= cfg_data_i[CfgHeightW-1:0];
        default: ;
      endcase
    end
  end

  // Raster position counters; a register write or the last output restarts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      in_done_q <= 1'b0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else if (cfg_valid_i) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      in_done_q <= 1'b0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      if (do_wr) begin
        if (in_col_q == w_last) begin
          in_col_q <= '0;
          if (in_row_q == h_last) begin
            in_done_q <= 1'b1;
          end else begin
            in_row_q <= in_row_q + 1'b1;
          end
        end else begin
          in_col_q <= in_col_q + 1'b1;
        end
      end
      if (emit) begin
        if (last) begin
          in_col_q  <= '0;
          in_row_q  <= '0;
          in_done_q <= 1'b0;
          out_col_q <= '0;
          out_row_q <= '0;
        end else if (out_col_q == w_last) begin
          out_col_q <= '0;
          out_row_q <= out_row_q + 1'b1;
        end else begin
          out_col_q <= out_col_q + 1'b1;
        end
      end
    end
  end

endmodule

// File: hw/rtl/rmf_window.sv
// ----------------------------------------------------------------------------
// rmf_window: line store and 3x3 window
// Reads the two rows above the incoming pixel from the line store, writes
// the shifted column back, and assembles the window of each output pixel.
// ----------------------------------------------------------------------------
module rmf_window import rmf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  item_valid_i,
  input  item_t item_i,
  output logic  ready_o,
  output logic  win_valid_o,
  input  logic  win_ready_i,
  output win_t  win_o,
  output tag_t  tag_o
);

  logic       a_valid_q;
  item_t      a_q;
  logic       fwd_q;
  line_word_t fwd_word_q;
  line_word_t ram_rdata, rd, wr_word;
  col_t       w0_q, w1_q, new_col;
  logic       b_valid_q;
  win_t       b_win_q, win_d;
  tag_t       b_tag_q;
  logic       b_free, a_move, fwd_hit;

  // Stage handshake: the window stage only waits for space downstream.
  assign b_free  = !b_valid_q || win_ready_i;
  assign a_move  = a_valid_q && (!a_q.emit || b_free);
  assign ready_o = !a_valid_q || a_move;

  // The store word written back at this edge is read by the entering item.
  assign fwd_hit = item_valid_i && a_move && a_q.wr && (a_q.col == item_i.col);

  rmf_ram #(
    .Width ($bits(line_word_t)),
    .Depth (MaxWidth)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (a_move && a_q.wr),
    .waddr_i (a_q.col),
    .wdata_i (wr_word),
    .re_i    (item_valid_i),
    .raddr_i (item_i.col),
    .rdata_o (ram_rdata)
  );

  // Column under the incoming pixel and the word written back.
  always_comb begin
    rd          = fwd_q ? fwd_word_q : ram_rdata;
    new_col[0]  = rd.top;
    new_col[1]  = rd.mid;
    new_col[2]  = a_q.pix;
    wr_word.top = rd.mid;
    wr_word.mid = a_q.pix;
  end

  // Window of the output pixel: columns C-2, C-1 and C.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_d[3*i]     = w1_q[i];
      win_d[3*i + 1] = w0_q[i];
      win_d[3*i + 2] = new_col[i];
    end
    if (a_q.from_mem) begin
      win_d[WinCenter] = rd.mid;
    end
  end

  // Read stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      fwd_q     <= 1'b0;
    end else begin
      if (ready_o) begin
        a_valid_q <= item_valid_i;
      end
      if (item_valid_i) begin
        fwd_q <= fwd_hit;
      end
    end
  end

  // Read stage payload.
  always_ff @(posedge clk_i) begin
    if (item_valid_i) begin
      a_q        <= item_i;
      fwd_word_q <= wr_word;
    end
  end

  // Window column registers shift on every stored pixel.
  always_ff @(posedge clk_i) begin
    if (a_move && a_q.wr) begin
      w1_q <= w0_q;
      w0_q <= new_col;
    end
  end

  // Window output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_free) begin
      b_valid_q <= a_move && a_q.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_free && a_move && a_q.emit) begin
      b_win_q          <= win_d;
      b_tag_q.interior <= a_q.interior;
      b_tag_q.last     <= a_q.last;
    end
  end

  assign win_valid_o = b_valid_q;
  assign win_o       = b_win_q;
  assign tag_o       = b_tag_q;

  // A median window always comes from a pixel that was just stored.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q && a_q.interior |-> a_q.wr)
    else $error("interior output without a stored pixel");

  // A pending pixel read from the store belongs to a drain request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q && a_q.from_mem |-> a_q.emit && !a_q.wr)
    else $error("store read for an output on a pixel request");

  // No request may enter while the read stage holds its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q && !a_move |-> !item_valid_i)
    else $error("request entered a stalled read stage");

endmodule

// File: hw/rtl/rmf_median.sv
// ----------------------------------------------------------------------------
// rmf_median: brightness median of a 3x3 window
// Three stages: brightness sums, pairwise ordering, rank select into the
// output register. Border pixels pass the window center unchanged.
// ----------------------------------------------------------------------------
module rmf_median import rmf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  win_t win_i,
  input  tag_t tag_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output pix_t out_pix_o,
  output logic out_last_o
);

  logic                                c_valid_q, d_valid_q, o_valid_q;
  logic                                c_free, d_free, o_free;
  win_t                                c_win_q, d_win_q;
  tag_t                                c_tag_q, d_tag_q;
  logic [WinSize-1:0][BrW-1:0]         br_d, c_br_q;
  logic [WinSize-1:0][WinSize-1:0]     bf_d, d_bf_q;
  logic [WinSize-1:0]                  sel;
  logic [WinSize-1:0][RankW:0]         rank;
  pix_t                                med, o_pix_q;
  logic                                o_last_q;

  assign o_free  = !o_valid_q || out_ready_i;
  assign d_free  = !d_valid_q || o_free;
  assign c_free  = !c_valid_q || d_free;
  assign ready_o = c_free;

  // Brightness of each window pixel.
  always_comb begin
    for (int k = 0; k < WinSize; k++) begin
      br_d[k] = BrW'(win_i[k][ChanW-1:0]) + BrW'(win_i[k][2*ChanW-1:ChanW]) +
                BrW'(win_i[k][3*ChanW-1:2*ChanW]);
    end
  end

  // bf[i][j] is set when pixel j ranks before pixel i; ties keep window order.
  always_comb begin
    bf_d = '0;
    for (int i = 0; i < WinSize; i++) begin
      for (int j = i + 1; j < WinSize; j++) begin
        bf_d[i][j] = c_br_q[j] < c_br_q[i];
        bf_d[j][i] = !(c_br_q[j] < c_br_q[i]);
      end
    end
  end

  // The pixel with exactly four predecessors is the median.
  always_comb begin
    med = '0;
    for (int i = 0; i < WinSize; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WinSize; j++) begin
        rank[i] = rank[i] + (RankW + 1)'(d_bf_q[i][j]);
      end
      sel[i] = (rank[i] == (RankW + 1)'(MedRank));
      if (sel[i]) begin
        med = med | d_win_q[i];
      end
    end
  end

  // Stage valids.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (c_free) c_valid_q <= valid_i;
      if (d_free) d_valid_q <= c_valid_q;
      if (o_free) o_valid_q <= d_valid_q;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (c_free && valid_i) begin
      c_win_q <= win_i;
      c_tag_q <= tag_i;
      c_br_q  <= br_d;
    end
    if (d_free && c_valid_q) begin
      d_win_q <= c_win_q;
      d_tag_q <= c_tag_q;
      d_bf_q  <= bf_d;
    end
    if (o_free && d_valid_q) begin
      o_pix_q  <= d_tag_q.interior ? med : d_win_q[WinCenter];
      o_last_q <= d_tag_q.last;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_pix_o   = o_pix_q;
  assign out_last_o  = o_last_q;

  // The pairwise order is total, so exactly one pixel holds the median rank.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    d_valid_q && d_tag_q.interior |-> $onehot(sel))
    else $error("median rank not unique");

endmodule
